// ----- hdl/hcbd_pkg.sv -----
// Shared types and constants for the home computer bank decoder.
package hcbd_pkg;

  // Target codes
  localparam logic [3:0] TGT_RAM     = 4'd0;
  localparam logic [3:0] TGT_BASIC   = 4'd1;
  localparam logic [3:0] TGT_KERNAL  = 4'd2;
  localparam logic [3:0] TGT_CHARGEN = 4'd3;
  localparam logic [3:0] TGT_VIC     = 4'd4;
  localparam logic [3:0] TGT_SID     = 4'd5;
  localparam logic [3:0] TGT_COLOR   = 4'd6;
  localparam logic [3:0] TGT_CIA1    = 4'd7;
  localparam logic [3:0] TGT_CIA2    = 4'd8;
  localparam logic [3:0] TGT_OPEN    = 4'd9;

  // Per-mode presence masks, bit n set when mode n maps the area in
  localparam logic [7:0] BASIC_MODES  = 8'b1000_1000;
  localparam logic [7:0] KERNAL_MODES = 8'b1100_1100;
  localparam logic [7:0] IO_MODES     = 8'b1110_0000;
  localparam logic [7:0] CHAR_MODES   = 8'b0000_1110;

  localparam logic [15:0] BANK_PORT_ADDR = 16'h0001;
  localparam logic [15:0] CIA2_PORT_ADDR = 16'hDD00;
  localparam logic [5:0]  VIC_PTR_REG    = 6'h18;

  localparam logic [2:0] MODE_RESET = 3'd7;
  localparam logic [1:0] VBANK_RESET = 2'd3;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
  } hcbd_in_t;

  typedef struct packed {
    logic [3:0]  target;
    logic [15:0] offset;
    logic        ram_write;
    logic [3:0]  color_nibble;
    logic        open_read;
    logic [2:0]  bank_mode_now;
    logic [1:0]  screen_bank;
    logic [15:0] matrix_address;
    logic [15:0] bitmap_address;
    logic [15:0] char_address;
    logic        char_from_rom;
  } hcbd_out_t;

  // State updates caused by one access
  typedef struct packed {
    logic       mode_we;
    logic [2:0] mode;
    logic       vbank_we;
    logic [1:0] vbank;
    logic       ptr_we;
    logic [7:0] ptr;
  } hcbd_upd_t;

endpackage

// ----- hdl/home_computer_bank_decoder.sv -----
// Top level of the home computer bank decoder.
//
// Usage:
//   One bus access per beat enters on in_valid/in_ready/in_data (command,
//   address, write data). For each one a single result beat leaves on
//   out_valid/out_ready/out_data: target, offset within it, RAM write
//   strobe, colour nibble, open-bus read flag, the banking mode and video
//   bank after the access, and the matrix, bitmap and character bases.
//   Each input beat is held in an input register; decode logic then feeds
//   the result register, which drives out_valid and out_data. Throughput
//   is one access per cycle while the receiver does not stall; the decode
//   and state update happen as a beat moves from the input register to
//   the result register, so the next access already sees the new banking
//   state.
//   When the receiver stalls the result register holds and the input
//   register still takes one more beat; in_ready then drops.
//   Reset (rst, synchronous) empties both registers and sets banking mode 7,
//   video bank 3 and video pointer zero.
module home_computer_bank_decoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hcbd_pkg::hcbd_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hcbd_pkg::hcbd_out_t out_data
);
  import hcbd_pkg::*;

  hcbd_in_t  acc;
  logic      acc_valid;
  logic      advance;

  logic [2:0] bank_mode, bank_mode_next;
  logic [1:0] vbank, vbank_next;
  logic [7:0] ptr, ptr_next;

  hcbd_upd_t  upd;
  hcbd_out_t  res;

  assign advance  = acc_valid && (!out_valid || out_ready);
  assign in_ready = !acc_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (in_ready) begin
      acc_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      acc <= in_data;
    end
  end

  hcbd_route u_route (
    .acc          (acc),
    .mode         (bank_mode),
    .target       (res.target),
    .offset       (res.offset),
    .ram_write    (res.ram_write),
    .color_nibble (res.color_nibble),
    .open_read    (res.open_read),
    .upd          (upd)
  );

  assign bank_mode_next = upd.mode_we  ? upd.mode  : bank_mode;
  assign vbank_next     = upd.vbank_we ? upd.vbank : vbank;
  assign ptr_next       = upd.ptr_we   ? upd.ptr   : ptr;

  assign res.bank_mode_now = bank_mode_next;
  assign res.screen_bank   = vbank_next;

  hcbd_video u_video (
    .vbank          (vbank_next),
    .ptr            (ptr_next),
    .matrix_address (res.matrix_address),
    .bitmap_address (res.bitmap_address),
    .char_address   (res.char_address),
    .char_from_rom  (res.char_from_rom)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      bank_mode <= MODE_RESET;
      vbank     <= VBANK_RESET;
      ptr       <= 8'd0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        bank_mode <= bank_mode_next;
        vbank     <= vbank_next;
        ptr       <= ptr_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_data <= res;
    end
  end

endmodule

// ----- hdl/hcbd_route.sv -----
// Address routing: picks the target and offset of one bus access, and the state updates it causes.
module hcbd_route (
  input  hcbd_pkg::hcbd_in_t  acc,
  input  logic [2:0]          mode,
  output logic [3:0]          target,
  output logic [15:0]         offset,
  output logic                ram_write,
  output logic [3:0]          color_nibble,
  output logic                open_read,
  output hcbd_pkg::hcbd_upd_t upd
);
  import hcbd_pkg::*;

  logic        wr;
  logic [15:0] a;
  logic        in_basic, in_kernal, in_d000;

  assign wr        = acc.command;
  assign a         = acc.address;
  assign in_basic  = (a[15:13] == 3'b101);
  assign in_kernal = (a[15:13] == 3'b111);
  assign in_d000   = (a[15:12] == 4'hD);

  always_comb begin
    target       = TGT_RAM;
    offset       = a;
    ram_write    = 1'b0;
    color_nibble = 4'd0;
    open_read    = 1'b0;
    upd          = '0;
    upd.mode     = acc.write_data[2:0];
    upd.vbank    = ~acc.write_data[1:0];
    upd.ptr      = acc.write_data;

    if (in_basic && BASIC_MODES[mode] && !wr) begin
      target = TGT_BASIC;
      offset = {3'd0, a[12:0]};
    end else if (in_kernal && KERNAL_MODES[mode] && !wr) begin
      target = TGT_KERNAL;
      offset = {3'd0, a[12:0]};
    end else if (in_d000 && IO_MODES[mode]) begin
      case (a[11:8]) inside
        [4'h0:4'h3]: begin
          target = TGT_VIC;
          offset = {10'd0, a[5:0]};
          upd.ptr_we = wr && (a[5:0] == VIC_PTR_REG);
        end
        [4'h4:4'h7]: begin
          target = TGT_SID;
          offset = {11'd0, a[4:0]};
        end
        [4'h8:4'hB]: begin
          target = TGT_COLOR;
          offset = {6'd0, a[9:0]};
          if (wr) color_nibble = acc.write_data[3:0];
        end
        4'hC: begin
          target = TGT_CIA1;
          offset = {12'd0, a[3:0]};
        end
        4'hD: begin
          target = TGT_CIA2;
          offset = {12'd0, a[3:0]};
          upd.vbank_we = wr && (a == CIA2_PORT_ADDR);
        end
        default: begin
          target    = TGT_OPEN;
          offset    = {7'd0, a[8:0]};
          open_read = !wr;
        end
      endcase
    end else if (in_d000 && CHAR_MODES[mode] && !wr) begin
      target = TGT_CHARGEN;
      offset = {4'd0, a[11:0]};
    end else begin
      ram_write   = wr;
      upd.mode_we = wr && (a == BANK_PORT_ADDR);
    end
  end

endmodule

// ----- hdl/hcbd_video.sv -----
// Video base addresses from the bank index and the VIC pointer byte.
module hcbd_video (
  input  logic [1:0]  vbank,
  input  logic [7:0]  ptr,
  output logic [15:0] matrix_address,
  output logic [15:0] bitmap_address,
  output logic [15:0] char_address,
  output logic        char_from_rom
);
  import hcbd_pkg::*;

  logic [15:0] cbase;

  // Pointer fields land below the bank base bits, so no adder is needed
  assign matrix_address = {vbank, ptr[7:4], 10'd0};
  assign bitmap_address = {vbank, ptr[3], 13'd0};
  assign cbase          = {vbank, ptr[3:1], 11'd0};
  // Character ROM shadows 1000-1FFF in banks 0 and 2
  assign char_from_rom  = !vbank[0] && (ptr[3:2] == 2'b01);
  assign char_address   = char_from_rom ? {4'd0, cbase[11:0]} : cbase;

endmodule
